>>> sv/cdi_pkg.sv
// Shared widths, payload types and sequencer controls for the curvature double integrator.
package cdi_pkg;

  localparam int IDX_W     = 16;
  localparam int SUM_W     = 32;
  localparam int CNT_IN_W  = 16;
  localparam int LEN_W     = 16;
  localparam int POS_W     = 40;
  localparam int DEFL_W    = 48;
  localparam int ACC_W     = 48;
  localparam int KSUM_W    = SUM_W + 1;
  localparam int DIFF_W    = IDX_W + 1;
  localparam int DX_W      = DIFF_W + LEN_W;
  localparam int POS_PROD_W = IDX_W + LEN_W + 1;
  localparam int MUL_A_W   = ACC_W + 1;
  localparam int PROD_W    = MUL_A_W + 1 + DX_W;
  localparam int PROD_SHIFT = 13;
  localparam int TOTAL_W   = PROD_W - PROD_SHIFT + 1;
  localparam int DIV_STEPS = SUM_W;
  localparam int MUL_STEPS = DX_W;
  localparam int SEQ_W     = $clog2(MUL_STEPS + 1);

  localparam logic [LEN_W-1:0] SEG_LEN_RST = LEN_W'(4096);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic signed [IDX_W-1:0]  bin_index;
    logic signed [SUM_W-1:0]  sum_y;
    logic signed [SUM_W-1:0]  sum_z;
    logic [CNT_IN_W-1:0]      sample_count;
    logic                     last_bin;
  } bin_beat_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  position;
    logic signed [DEFL_W-1:0] deflection_y;
    logic signed [DEFL_W-1:0] deflection_z;
    logic                     end_of_run;
  } res_beat_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
    logic sign_step;
  } mul_ctl_t;

endpackage

>>> sv/cdi_div.sv
// Bit-serial restoring divider: signed sum over unsigned count, truncated toward zero.
module cdi_div (
  input  logic                                 clk,
  input  cdi_pkg::div_ctl_t                    ctl,
  input  logic signed [cdi_pkg::SUM_W-1:0]     sum,
  input  logic [cdi_pkg::CNT_IN_W-1:0]         count,
  output logic signed [cdi_pkg::SUM_W-1:0]     quot
);
  import cdi_pkg::*;

  logic [SUM_W-1:0]    q;
  logic [CNT_IN_W-1:0] r;
  logic [CNT_IN_W-1:0] d;
  logic                neg;
  logic                zero;
  logic [CNT_IN_W:0]   trial;
  logic [CNT_IN_W:0]   trial_sub;

  assign trial     = {r, q[SUM_W-1]};
  assign trial_sub = trial - {1'b0, d};
  assign quot      = zero ? '0 : (neg ? -$signed(q) : $signed(q));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q    <= sum[SUM_W-1] ? SUM_W'(-sum) : sum;
      r    <= '0;
      d    <= count;
      neg  <= sum[SUM_W-1];
      zero <= (count == '0);
    end else if (ctl.step) begin
      // one quotient bit per cycle
      if (trial >= {1'b0, d}) begin
        r <= trial_sub[CNT_IN_W-1:0];
        q <= {q[SUM_W-2:0], 1'b1};
      end else begin
        r <= trial[CNT_IN_W-1:0];
        q <= {q[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/cdi_mul.sv
// Bit-serial signed multiplier with floor shift, accumulate and saturation.
module cdi_mul (
  input  logic                                 clk,
  input  cdi_pkg::mul_ctl_t                    ctl,
  input  logic signed [cdi_pkg::MUL_A_W-1:0]   a,
  input  logic signed [cdi_pkg::DX_W-1:0]      b,
  input  logic signed [cdi_pkg::ACC_W-1:0]     acc,
  output logic signed [cdi_pkg::ACC_W-1:0]     result
);
  import cdi_pkg::*;

  logic signed [MUL_A_W-1:0] a_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [DX_W-1:0]           b_sh;
  logic [MUL_A_W:0]          hi;
  logic [DX_W-1:0]           lo;
  logic signed [MUL_A_W+1:0] ext_a;
  logic signed [MUL_A_W+1:0] addend;
  logic [MUL_A_W+1:0]        psum;
  logic [PROD_W-1:0]         prod;
  logic signed [TOTAL_W-1:0] total;
  logic [TOTAL_W-ACC_W:0]    top_bits;

  always_comb begin
    ext_a = {{2{a_q[MUL_A_W-1]}}, a_q};
    addend = '0;
    if (b_sh[0]) begin
      // the sign bit of b carries negative weight
      addend = ctl.sign_step ? -ext_a : ext_a;
    end
    psum = {hi[MUL_A_W], hi} + addend;
  end

  assign prod  = {hi, lo};
  assign total = {{(TOTAL_W-(PROD_W-PROD_SHIFT)){prod[PROD_W-1]}},
                  prod[PROD_W-1:PROD_SHIFT]}
               + {{(TOTAL_W-ACC_W){acc_q[ACC_W-1]}}, acc_q};
  assign top_bits = total[TOTAL_W-1:ACC_W-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      result = total[ACC_W-1:0];
    end else begin
      result = total[TOTAL_W-1] ? ACC_MIN : ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a_q   <= a;
      acc_q <= acc;
      b_sh  <= b;
      hi    <= '0;
      lo    <= '0;
    end else if (ctl.step) begin
      hi   <= psum[MUL_A_W+1:1];
      lo   <= {psum[0], lo[DX_W-1:1]};
      b_sh <= b_sh >> 1;
    end
  end

endmodule

>>> sv/curvature_double_integrator.sv
// Top level: sequencer, state and result register of the curvature double integrator.
//
// Usage: curvature bins enter on the bin channel (bin_valid / bin_stall / bin_data) in
// ascending index order; one result beat per bin leaves on the res channel
// (res_valid / res_stall / res_data). The first bin of a stream gives zero deflection;
// a stream of a single bin gives no beat at all. The bin length register (seg_len) is
// written through cfg_write / cfg_wdata by the user, who must do so only while the
// block is idle; the block itself does not enforce this. Timing: a bin beat is taken
// only while the sequencer is idle. Both mean curvatures come from bit-serial dividers.
// A bin that continues a stream then runs two bit-serial multiply passes (slope, then
// deflection), one bit of dx per cycle. The next bin is not taken until the sequencer
// is done with the current one; the serial multiply passes set the pace.
// Reset (rst, synchronous) clears the stream state, the accumulators and res_valid and
// sets seg_len to 4096. A stalled result beat holds in the output register; the
// next bin is still taken and worked on, and only its write-back waits for the slot.
module curvature_double_integrator_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         bin_valid,
  output logic                         bin_stall,
  input  cdi_pkg::bin_beat_t           bin_data,
  output logic                         res_valid,
  input  logic                         res_stall,
  output cdi_pkg::res_beat_t           res_data,
  input  logic                         cfg_write,
  input  logic [cdi_pkg::LEN_W-1:0]    cfg_wdata
);
  import cdi_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_SLOPE = 5'b00100,
    S_OFFS  = 5'b01000,
    S_DONE  = 5'b10000
  } seq_state_t;

  seq_state_t state, state_next;
  logic [SEQ_W-1:0] cnt, cnt_next;

  // stream state
  logic                     have_prev;
  logic signed [IDX_W-1:0]  prev_idx;
  logic signed [SUM_W-1:0]  prev_ky, prev_kz;
  logic signed [ACC_W-1:0]  slope_y, slope_z, offset_y, offset_z;
  logic [LEN_W-1:0]         seg_len;

  // per-bin work registers
  logic signed [IDX_W-1:0]  idx_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [DX_W-1:0]   dx;
  logic signed [POS_W-1:0]  pos_q;
  logic                     last_q;
  logic signed [ACC_W-1:0]  ny_y, ny_z;

  logic accept, commit, emit, in_mul;
  logic signed [POS_PROD_W-1:0] pos_prod;
  logic signed [DX_W-1:0]       dx_prod;
  logic signed [SUM_W-1:0]      ky, kz;
  logic signed [KSUM_W-1:0]     ksum_y, ksum_z;
  logic signed [MUL_A_W-1:0]    ssum_y, ssum_z;
  logic signed [MUL_A_W-1:0]    mul_a_y, mul_a_z;
  logic signed [ACC_W-1:0]      mul_acc_y, mul_acc_z;
  logic signed [ACC_W-1:0]      mul_res_y, mul_res_z;
  div_ctl_t div_ctl;
  mul_ctl_t mul_ctl;

  assign bin_stall = (state != S_IDLE);
  assign accept    = bin_valid && !bin_stall;
  assign commit    = (state == S_DONE) && (!res_valid || !res_stall);
  assign emit      = have_prev || !last_q;
  assign in_mul    = (state == S_SLOPE) || (state == S_OFFS);

  assign pos_prod = $signed({{(POS_PROD_W-IDX_W){bin_data.bin_index[IDX_W-1]}},
                             bin_data.bin_index})
                  * $signed({{(POS_PROD_W-LEN_W){1'b0}}, seg_len});
  assign dx_prod  = $signed({{(DX_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q})
                  * $signed({{(DX_W-LEN_W){1'b0}}, seg_len});

  // controls for the serial units
  assign div_ctl.load      = accept;
  assign div_ctl.step      = (state == S_DIV);
  assign mul_ctl.load      = in_mul && (cnt == '0);
  assign mul_ctl.step      = in_mul && (cnt != '0);
  assign mul_ctl.sign_step = (cnt == SEQ_W'(MUL_STEPS));

  // multiplicands: curvature sum for the slope pass, slope sum for the deflection pass;
  // at the deflection load the multiplier still shows the new slope
  assign ksum_y  = {prev_ky[SUM_W-1], prev_ky} + {ky[SUM_W-1], ky};
  assign ksum_z  = {prev_kz[SUM_W-1], prev_kz} + {kz[SUM_W-1], kz};
  assign ssum_y  = {slope_y[ACC_W-1], slope_y} + {mul_res_y[ACC_W-1], mul_res_y};
  assign ssum_z  = {slope_z[ACC_W-1], slope_z} + {mul_res_z[ACC_W-1], mul_res_z};
  assign mul_a_y = (state == S_SLOPE) ? {{(MUL_A_W-KSUM_W){ksum_y[KSUM_W-1]}}, ksum_y}
                                      : ssum_y;
  assign mul_a_z = (state == S_SLOPE) ? {{(MUL_A_W-KSUM_W){ksum_z[KSUM_W-1]}}, ksum_z}
                                      : ssum_z;
  assign mul_acc_y = (state == S_SLOPE) ? slope_y : offset_y;
  assign mul_acc_z = (state == S_SLOPE) ? slope_z : offset_z;

  cdi_div u_div_y (
    .clk   (clk),
    .ctl   (div_ctl),
    .sum   (bin_data.sum_y),
    .count (bin_data.sample_count),
    .quot  (ky)
  );

  cdi_div u_div_z (
    .clk   (clk),
    .ctl   (div_ctl),
    .sum   (bin_data.sum_z),
    .count (bin_data.sample_count),
    .quot  (kz)
  );

  cdi_mul u_mul_y (
    .clk    (clk),
    .ctl    (mul_ctl),
    .a      (mul_a_y),
    .b      (dx),
    .acc    (mul_acc_y),
    .result (mul_res_y)
  );

  cdi_mul u_mul_z (
    .clk    (clk),
    .ctl    (mul_ctl),
    .a      (mul_a_z),
    .b      (dx),
    .acc    (mul_acc_z),
    .result (mul_res_z)
  );

  // sequencer
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DIV;
          cnt_next   = '0;
        end
      end
      S_DIV: begin
        if (cnt == SEQ_W'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          // a first bin skips both integration passes
          state_next = have_prev ? S_SLOPE : S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SLOPE: begin
        if (cnt == SEQ_W'(MUL_STEPS)) begin
          cnt_next   = '0;
          state_next = S_OFFS;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_OFFS: begin
        if (cnt == SEQ_W'(MUL_STEPS)) begin
          cnt_next   = '0;
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  // control and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      have_prev  <= 1'b0;
      prev_idx   <= '0;
      prev_ky    <= '0;
      prev_kz    <= '0;
      slope_y    <= '0;
      slope_z    <= '0;
      offset_y   <= '0;
      offset_z   <= '0;
      seg_len    <= SEG_LEN_RST;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_write) begin
        seg_len <= cfg_wdata;
      end
      // a new beat replaces the one leaving in the same cycle
      if (commit && emit) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (commit) begin
        prev_idx  <= idx_q;
        prev_ky   <= ky;
        prev_kz   <= kz;
        have_prev <= !last_q;
        if (have_prev) begin
          slope_y  <= ny_y;
          slope_z  <= ny_z;
          offset_y <= mul_res_y;
          offset_z <= mul_res_z;
        end else begin
          // a new stream starts from rest
          slope_y  <= '0;
          slope_z  <= '0;
          offset_y <= '0;
          offset_z <= '0;
        end
      end
    end
  end

  // per-bin payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_q  <= bin_data.bin_index;
      last_q <= bin_data.last_bin;
      diff_q <= {bin_data.bin_index[IDX_W-1], bin_data.bin_index}
              - {prev_idx[IDX_W-1], prev_idx};
      pos_q  <= {{(POS_W-POS_PROD_W){pos_prod[POS_PROD_W-1]}}, pos_prod}
              + {{(POS_W-LEN_W+1){1'b0}}, seg_len[LEN_W-1:1]};
    end
    if (state == S_DIV) begin
      dx <= dx_prod;
    end
    // capture the new slope while the deflection pass loads
    if (state == S_OFFS && cnt == '0) begin
      ny_y <= mul_res_y;
      ny_z <= mul_res_z;
    end
    if (commit && emit) begin
      res_data.position     <= pos_q;
      res_data.deflection_y <= have_prev ? mul_res_y : '0;
      res_data.deflection_z <= have_prev ? mul_res_z : '0;
      res_data.end_of_run   <= last_q;
    end
  end

  // checks
  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_DIV)
    else $error("accepted bin did not start the divide pass");

  a_commit_to_idle: assert property (@(posedge clk) disable iff (rst)
    commit |=> state == S_IDLE)
    else $error("sequencer did not return to idle after write-back");

  a_single_bin_silent: assert property (@(posedge clk) disable iff (rst)
    commit && !have_prev && last_q |=> !res_valid)
    else $error("single-bin stream produced a result beat");

  a_eor_matches: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> res_data.end_of_run == last_q)
    else $error("end_of_run does not match the bin's last flag");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= SEQ_W'(MUL_STEPS))
    else $error("step counter out of range");

endmodule

>>> tb/sv/curvature_double_integrator_core_tb.sv
// Self-checking testbench for the curvature double integrator core.
`timescale 1ns / 100ps

module curvature_double_integrator_core_tb;
  import cdi_pkg::*;

  // Deflection accumulators saturate at 48 bits signed.
  localparam longint DEFL_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint DEFL_BOT = -DEFL_TOP - 1;
  // A lone bin that yields no beat can still be in flight once every owed beat has
  // come out, so hold off for BUSY_GUARD before a write.
  localparam int BUSY_GUARD  = 120;
  localparam int HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct {
    bin_beat_t beat;
    bit        typed;   // expectation written out below instead of predicted
    bit        yields;  // typed row produces a result beat
    res_beat_t res;
  } bin_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       bin_valid = 1'b0;
  logic       bin_stall;
  bin_beat_t  bin_data = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  res_beat_t  res_data;
  logic       cfg_write = 1'b0;
  logic [LEN_W-1:0] cfg_wdata = '0;

  curvature_double_integrator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .bin_valid (bin_valid),
    .bin_stall (bin_stall),
    .bin_data  (bin_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .cfg_write (cfg_write),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Integrator predictor: its own copy of the register and the stream state.
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0]        len_copy = SEG_LEN_RST;
  bit                      run_open;
  logic signed [IDX_W-1:0] prev_idx;
  longint                  prev_ky, prev_kz;
  longint                  slope_y, slope_z, defl_y, defl_z;

  res_beat_t pending_results[$];  // deflection beats still owed by the block

  int  errors, bins_taken, results_seen, runs_closed;
  int  send_idle_pct, stall_pct;
  bit  hold_req;
  int  hold_left;
  int  run_cycles;
  res_beat_t want;
  bin_row_t  dir_rows[$];

  // Mean curvature, truncated toward zero; an empty bin counts as flat.
  function automatic longint mean_of(logic signed [SUM_W-1:0] s, logic [CNT_IN_W-1:0] n);
    if (n == 0) return 0;
    return longint'(s) / longint'(n);
  endfunction

  // One trapezoid step: acc + floor((a + b) * dx / 2^13), exact product, saturated.
  function automatic longint trap_acc(longint acc, longint a, longint b, longint dx);
    logic signed [127:0] wa, wb, wd, wacc, prod, total;
    wa = 128'(a);
    wb = 128'(b);
    wd = 128'(dx);
    wacc = 128'(acc);
    prod = wa * wd + wb * wd;
    total = wacc + (prod >>> PROD_SHIFT);
    if (total > DEFL_TOP) return DEFL_TOP;
    if (total < DEFL_BOT) return DEFL_BOT;
    return longint'(total[63:0]);
  endfunction

  // Advance the stream state by one bin; got is low for a lone single-bin stream.
  task automatic integrate_bin(input bin_beat_t b, output bit got, output res_beat_t r);
    logic signed [IDX_W-1:0] idx;
    longint ky, kz, pos, dx, ny, nz;
    idx = b.bin_index;
    ky = mean_of(b.sum_y, b.sample_count);
    kz = mean_of(b.sum_z, b.sample_count);
    pos = longint'(idx) * longint'(len_copy) + longint'(len_copy >> 1);
    got = 1'b0;
    r = '0;
    if (!run_open) begin
      // first bin of a stream: clear the accumulators and remember the bin
      slope_y = 0;
      slope_z = 0;
      defl_y = 0;
      defl_z = 0;
      prev_idx = idx;
      prev_ky = ky;
      prev_kz = kz;
      if (b.last_bin) return;
      run_open = 1'b1;
    end else begin
      // signed index difference, so gaps stretch dx and a step back integrates backwards
      dx = (longint'(idx) - longint'(prev_idx)) * longint'(len_copy);
      ny = trap_acc(slope_y, prev_ky, ky, dx);
      nz = trap_acc(slope_z, prev_kz, kz, dx);
      defl_y = trap_acc(defl_y, slope_y, ny, dx);
      defl_z = trap_acc(defl_z, slope_z, nz, dx);
      slope_y = ny;
      slope_z = nz;
      prev_idx = idx;
      prev_ky = ky;
      prev_kz = kz;
      if (b.last_bin) run_open = 1'b0;
    end
    got = 1'b1;
    r.position = pos[POS_W-1:0];
    r.deflection_y = defl_y[DEFL_W-1:0];
    r.deflection_z = defl_z[DEFL_W-1:0];
    r.end_of_run = b.last_bin;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic bin_beat_t mk_bin(int idx, int sy, int sz, int n, bit closes);
    bin_beat_t b;
    b.bin_index = idx[IDX_W-1:0];
    b.sum_y = sy;
    b.sum_z = sz;
    b.sample_count = n[CNT_IN_W-1:0];
    b.last_bin = closes;
    return b;
  endfunction

  function automatic res_beat_t mk_res(longint pos, longint dy, longint dz, bit eor);
    res_beat_t r;
    r.position = pos[POS_W-1:0];
    r.deflection_y = dy[DEFL_W-1:0];
    r.deflection_z = dz[DEFL_W-1:0];
    r.end_of_run = eor;
    return r;
  endfunction

  // Mix of full-range, moderate, extreme and tiny curvature sums.
  function automatic logic signed [SUM_W-1:0] rand_sum();
    case ($urandom_range(4))
      0: return $urandom;
      1: return int'($urandom_range(0, 2097152)) - 1048576;
      2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      3: return int'($urandom_range(0, 2)) - 1;
      default: return int'($urandom_range(0, 67108864)) - 33554432;
    endcase
  endfunction

  function automatic logic [CNT_IN_W-1:0] rand_count();
    case ($urandom_range(5))
      0: return '0;
      1: return CNT_IN_W'(1);
      2: return CNT_IN_W'($urandom_range(2, 16));
      3: return 16'hFFFF;
      default: return CNT_IN_W'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic bin_beat_t rand_bin(logic signed [IDX_W-1:0] idx, logic closes);
    bin_beat_t b;
    b.bin_index = idx;
    b.sum_y = rand_sum();
    b.sum_z = rand_sum();
    b.sample_count = rand_count();
    b.last_bin = closes;
    return b;
  endfunction

  // Offer one bin beat, hold it until taken, then log what the block owes for it.
  // Valid stays high after the beat is taken; the next call replaces the beat or drop_valid lowers it.
  task automatic send_bin(input bin_beat_t b, input bit typed, input bit yields,
                          input res_beat_t typed_res);
    bit        got;
    res_beat_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      bin_valid <= 1'b0;
      @(posedge clk);
    end
    bin_valid <= 1'b1;
    bin_data <= b;
    do @(posedge clk); while (bin_stall);
    integrate_bin(b, got, r);
    if (typed) begin
      if (yields) pending_results.push_back(typed_res);
    end else if (got) begin
      pending_results.push_back(r);
    end
    bins_taken++;
  endtask

  task automatic drop_valid();
    bin_valid <= 1'b0;
  endtask

  // Hold the sender until every owed beat has come out.
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the bin length only with the block idle.
  task automatic set_seg_len(input logic [LEN_W-1:0] v);
    drop_valid();
    wait_drained();
    repeat (BUSY_GUARD) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    len_copy = v;
  endtask

  // Streams of one to eight bins with random content; one draw in ten sends a single noise
  // beat instead, and some streams never raise last_bin and so run into the next one.
  task automatic run_random(input int n);
    int made, run_len, k;
    logic signed [IDX_W-1:0] idx;
    bit closes;
    made = 0;
    while (made < n) begin
      if ($urandom_range(9) == 0) begin
        send_bin(rand_bin(16'($urandom), 1'($urandom)), 1'b0, 1'b0, '0);
        made++;
      end else begin
        run_len = $urandom_range(1, 8);
        idx = 16'($urandom);
        for (k = 0; k < run_len && made < n; k++) begin
          closes = (k == run_len - 1) && ($urandom_range(7) != 0);
          send_bin(rand_bin(idx, closes), 1'b0, 1'b0, '0);
          made++;
          idx += IDX_W'(($urandom_range(9) == 0) ? $urandom_range(2, 300) : 1);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: check each beat against the oldest owed one, then pick the
  // next stall. A long hold, once requested, is counted down here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got pos %0d dy %0d dz %0d eor %0b",
                 $time, res_data.position, res_data.deflection_y, res_data.deflection_z,
                 res_data.end_of_run);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (res_data.end_of_run) runs_closed++;
        if (res_data.position !== want.position) begin
          errors++;
          $display("%0t: position mismatch, expected %0d, got %0d",
                   $time, want.position, res_data.position);
        end
        if (res_data.deflection_y !== want.deflection_y) begin
          errors++;
          $display("%0t: deflection_y mismatch, expected %0d, got %0d",
                   $time, want.deflection_y, res_data.deflection_y);
        end
        if (res_data.deflection_z !== want.deflection_z) begin
          errors++;
          $display("%0t: deflection_z mismatch, expected %0d, got %0d",
                   $time, want.deflection_z, res_data.deflection_z);
        end
        if (res_data.end_of_run !== want.end_of_run) begin
          errors++;
          $display("%0t: end_of_run mismatch, expected %0b, got %0b",
                   $time, want.end_of_run, res_data.end_of_run);
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog on total run length.
  initial begin
    while (run_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      run_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Directed bins at the reset bin length of 4096.
    // first bin of a stream: centre at 2048, flat deflection
    dir_rows.push_back('{mk_bin(0, 0, 0, 1, 1'b0), 1'b1, 1'b1, mk_res(2048, 0, 0, 1'b0)});
    dir_rows.push_back('{mk_bin(1, 1 << 20, -(1 << 20), 1, 1'b0), 1'b0, 1'b0, '0});
    dir_rows.push_back('{mk_bin(2, 3 << 20, 5 << 19, 2, 1'b0), 1'b0, 1'b0, '0});
    // gap in the index with an empty bin
    dir_rows.push_back('{mk_bin(5, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0), 1'b0, 1'b0, '0});
    // repeated index, then a step back that closes the stream
    dir_rows.push_back('{mk_bin(5, 123, -456, 7, 1'b0), 1'b0, 1'b0, '0});
    dir_rows.push_back('{mk_bin(3, -1000, 1000, 3, 1'b1), 1'b0, 1'b0, '0});
    // lone bin that is also the last one: no beat
    dir_rows.push_back('{mk_bin(100, 77, 88, 1, 1'b1), 1'b1, 1'b0, '0});
    // most negative index, widest sums, full count
    dir_rows.push_back('{mk_bin(-32768, 32'h7FFF_FFFF, 32'h8000_0000, 65535, 1'b0),
                         1'b1, 1'b1, mk_res(-134215680, 0, 0, 1'b0)});
    // largest forward jump drives both accumulators into saturation
    dir_rows.push_back('{mk_bin(32767, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b0),
                         1'b0, 1'b0, '0});
    dir_rows.push_back('{mk_bin(32767, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b0),
                         1'b0, 1'b0, '0});
    dir_rows.push_back('{mk_bin(-32768, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b1),
                         1'b0, 1'b0, '0});
    // first bin at the top index with an empty count
    dir_rows.push_back('{mk_bin(32767, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1'b0),
                         1'b1, 1'b1, mk_res(134215680, 0, 0, 1'b0)});
    // tiny sums over a full count truncate to zero curvature
    dir_rows.push_back('{mk_bin(-1, -1, 1, 65535, 1'b0), 1'b0, 1'b0, '0});
    dir_rows.push_back('{mk_bin(0, 32'h8000_0000, 32'h7FFF_FFFF, 65535, 1'b1),
                         1'b0, 1'b0, '0});
    // lone last bin at the bottom index: no beat
    dir_rows.push_back('{mk_bin(-32768, 5, 6, 0, 1'b1), 1'b1, 1'b0, '0});
    dir_rows.push_back('{mk_bin(7, 1 << 20, 1 << 20, 1, 1'b0),
                         1'b1, 1'b1, mk_res(30720, 0, 0, 1'b0)});
    dir_rows.push_back('{mk_bin(8, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b0), 1'b0, 1'b0, '0});
    dir_rows.push_back('{mk_bin(1000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b0),
                         1'b0, 1'b0, '0});
    dir_rows.push_back('{mk_bin(2000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b1),
                         1'b0, 1'b0, '0});

    send_idle_pct = 0;
    stall_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_bin(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].yields, dir_rows[i].res);

    // Shortest bin, back to back on both sides.
    set_seg_len(16'd1);
    run_random(120);

    // Longest bin, sender mostly idle.
    set_seg_len(16'hFFFF);
    send_idle_pct = 88;
    run_random(70);

    // Random bin length, receiver mostly stalled.
    set_seg_len(16'($urandom_range(1, 65535)));
    send_idle_pct = 0;
    stall_pct = 88;
    run_random(70);

    // Short bins, light idling on both sides.
    set_seg_len(16'($urandom_range(1, 64)));
    send_idle_pct = 16;
    stall_pct = 16;
    run_random(70);

    // Back to the reset length; hold the output long enough for the block to
    // fill and stall its input while bins keep coming.
    set_seg_len(SEG_LEN_RST);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    run_random(20);
    // pause the sender until the backlog is gone, then finish with light idling
    drop_valid();
    wait_drained();
    send_idle_pct = 16;
    stall_pct = 16;
    run_random(30);

    drop_valid();
    wait_drained();
    repeat (BUSY_GUARD) @(posedge clk);

    $display("Covered %0d bins and %0d result beats (%0d closed runs), bin lengths 1 to 65535.",
             bins_taken, results_seen, runs_closed);
    $display("Included gaps, repeats, step-backs, empty bins, lone bins, saturation, long hold.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
